// ----- rtl/wcn_pkg.sv -----
// shared constants, types and helpers for the wall collision and normal block
package wcn_pkg;

    localparam int AREAS          = 9;
    localparam int SLOTS_PER_AREA = 16;
    localparam int COORD_BITS     = 10;
    localparam int RADIUS_BITS    = 8;
    localparam int AREA_BITS      = 4;
    localparam int SLOT_BITS      = 4;

    localparam int DEPTH  = AREAS * SLOTS_PER_AREA;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = (SLOTS_PER_AREA > 1) ? $clog2(SLOTS_PER_AREA) : 1;
    localparam int CALC_W = AREA_BITS + SLOT_BITS + 1;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [1:0] NORM_ZERO = 2'b00;
    localparam logic [1:0] NORM_POS  = 2'b01;
    localparam logic [1:0] NORM_NEG  = 2'b11;

    typedef struct packed {
        logic                  vertical;
        logic [COORD_BITS-1:0] fixed;
        logic [COORD_BITS-1:0] lo;
        logic [COORD_BITS-1:0] hi;
    } t_wall;

    // controller to datapath
    typedef struct packed {
        logic             wr_en;
        logic             start;
        logic             rd_en;
        logic [CNT_W-1:0] rd_slot;
        logic             load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic area_ok;
        logic slot_ok;
    } t_sts;

    function automatic logic [ADDR_W-1:0] addr_of(input logic [AREA_BITS-1:0] area,
                                                  input logic [CALC_W-1:0]    slot);
        logic [CALC_W-1:0] full;
        full = CALC_W'(area) * CALC_W'(SLOTS_PER_AREA) + slot;
        return full[ADDR_W-1:0];
    endfunction

endpackage

// ----- rtl/wcn_dpath.sv -----
// wall store, per-slot evaluation, accumulators and result register
module wcn_dpath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  wcn_pkg::t_cmd                   i_cmd,
    output wcn_pkg::t_sts                   o_sts,
    input  logic [wcn_pkg::AREA_BITS-1:0]   i_area,
    input  logic [wcn_pkg::SLOT_BITS-1:0]   i_slot,
    input  logic                            i_seg_vertical,
    input  logic [wcn_pkg::COORD_BITS-1:0]  i_seg_fixed,
    input  logic [wcn_pkg::COORD_BITS-1:0]  i_seg_min,
    input  logic [wcn_pkg::COORD_BITS-1:0]  i_seg_max,
    input  logic                            i_seg_valid,
    input  logic [wcn_pkg::COORD_BITS-1:0]  i_car_x,
    input  logic [wcn_pkg::COORD_BITS-1:0]  i_car_y,
    input  logic [wcn_pkg::RADIUS_BITS-1:0] i_car_radius,
    output logic                            o_hit,
    output logic signed [1:0]               o_normal_x,
    output logic signed [1:0]               o_normal_y
);
    import wcn_pkg::*;

    t_wall             r_mem [DEPTH];
    logic [DEPTH-1:0]  r_wall_vld;
    t_wall             r_rd_data;
    logic              r_rd_vld;
    logic              r_eval;

    logic [AREA_BITS-1:0]   r_area;
    logic [COORD_BITS-1:0]  r_cx;
    logic [COORD_BITS-1:0]  r_cy;
    logic [RADIUS_BITS-1:0] r_rad;

    logic                  r_hit;
    logic                  r_found;
    logic [COORD_BITS-1:0] r_best;
    logic [1:0]            r_nx;
    logic [1:0]            r_ny;
    logic                  r_o_hit;
    logic [1:0]            r_o_nx;
    logic [1:0]            r_o_ny;

    logic [ADDR_W-1:0]     waddr;
    logic [ADDR_W-1:0]     raddr;
    logic [COORD_BITS-1:0] perp;
    logic [COORD_BITS-1:0] along;
    logic [COORD_BITS-1:0] perp_dist;
    logic [COORD_BITS:0]   along_e;
    logic [COORD_BITS:0]   rad_e;
    logic                  hit_now;
    logic                  take;
    logic [1:0]            sgn;

    assign o_sts.area_ok = ({1'b0, i_area} < (AREA_BITS + 1)'(AREAS));
    assign o_sts.slot_ok = ({1'b0, i_slot} < (SLOT_BITS + 1)'(SLOTS_PER_AREA));

    assign waddr = addr_of(i_area, CALC_W'(i_slot));
    assign raddr = addr_of(r_area, CALC_W'(i_cmd.rd_slot));

    // wall store, one write or one read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[waddr] <= '{vertical: i_seg_vertical, fixed: i_seg_fixed,
                              lo: i_seg_min, hi: i_seg_max};
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wall_vld <= '0;
            r_rd_vld   <= 1'b0;
            r_eval     <= 1'b0;
        end else begin
            r_eval <= i_cmd.rd_en;
            if (i_cmd.wr_en) begin
                r_wall_vld[waddr] <= i_seg_valid;
            end
            if (i_cmd.rd_en) begin
                r_rd_vld <= r_wall_vld[raddr];
            end
        end
    end

    // slot evaluation
    always_comb begin
        perp      = r_rd_data.vertical ? r_cx : r_cy;
        along     = r_rd_data.vertical ? r_cy : r_cx;
        perp_dist = (perp > r_rd_data.fixed) ? (perp - r_rd_data.fixed)
                                             : (r_rd_data.fixed - perp);
        along_e   = {1'b0, along};
        rad_e     = (COORD_BITS + 1)'(r_rad);
        hit_now   = r_rd_vld && ({1'b0, perp_dist} <= rad_e)
                    && ((along_e + rad_e) >= {1'b0, r_rd_data.lo})
                    && (along_e <= ({1'b0, r_rd_data.hi} + rad_e));
        take      = r_rd_vld && (along >= r_rd_data.lo) && (along <= r_rd_data.hi)
                    && (!r_found || (perp_dist < r_best));
        sgn       = (perp > r_rd_data.fixed) ? NORM_POS : NORM_NEG;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_area  <= i_area;
            r_cx    <= i_car_x;
            r_cy    <= i_car_y;
            r_rad   <= i_car_radius;
            r_hit   <= 1'b0;
            r_found <= 1'b0;
            r_best  <= '0;
            r_nx    <= NORM_ZERO;
            r_ny    <= NORM_ZERO;
        end else if (r_eval) begin
            if (hit_now) begin
                r_hit <= 1'b1;
            end
            if (take) begin
                r_found <= 1'b1;
                r_best  <= perp_dist;
                r_nx    <= r_rd_data.vertical ? sgn : NORM_ZERO;
                r_ny    <= r_rd_data.vertical ? NORM_ZERO : sgn;
            end
        end
        if (i_cmd.load_out) begin
            r_o_hit <= r_hit;
            r_o_nx  <= r_nx;
            r_o_ny  <= r_ny;
        end
    end

    assign o_hit      = r_o_hit;
    assign o_normal_x = r_o_nx;
    assign o_normal_y = r_o_ny;

endmodule

// ----- rtl/wcn_ctrl.sv -----
// controller: handshakes, slot sweep and result hand-off
module wcn_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_func,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  wcn_pkg::t_sts i_sts,
    output wcn_pkg::t_cmd o_cmd
);
    import wcn_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DRAIN,
        S_FINISH
    } t_state;

    localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(SLOTS_PER_AREA - 1);

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_out_valid;
    logic             in_xfer;
    logic             out_free;

    assign in_xfer  = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd          = '0;
        o_cmd.wr_en    = in_xfer && (i_func == FUNC_WRITE) && i_sts.area_ok
                         && i_sts.slot_ok;
        o_cmd.start    = in_xfer && (i_func == FUNC_QUERY);
        o_cmd.rd_en    = (r_state == S_READ);
        o_cmd.rd_slot  = r_cnt;
        o_cmd.load_out = (r_state == S_FINISH) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a new result replaces the one taken in the same cycle
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (in_xfer && (i_func == FUNC_QUERY)) begin
                        r_state <= i_sts.area_ok ? S_READ : S_FINISH;
                    end
                end
                S_READ: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST_SLOT) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ----- rtl/axis_wall_collision_and_normal.sv -----
// top level: loadable axis-aligned wall store with collision and normal query
// a wall write is done on its transfer and the next transfer may follow at once
// a query sweeps the area's 16 slots, one store read a cycle, then a drain state
// finishes the last slot and a finish state loads the result once the output is
// free, next item accepted the cycle after; out-of-range area: straight to finish
// synchronous active-low reset marks every wall slot invalid
module axis_wall_collision_and_normal (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_func,
    input  logic [wcn_pkg::AREA_BITS-1:0]   i_area,
    input  logic [wcn_pkg::SLOT_BITS-1:0]   i_slot,
    input  logic                            i_seg_vertical,
    input  logic [wcn_pkg::COORD_BITS-1:0]  i_seg_fixed,
    input  logic [wcn_pkg::COORD_BITS-1:0]  i_seg_min,
    input  logic [wcn_pkg::COORD_BITS-1:0]  i_seg_max,
    input  logic                            i_seg_valid,
    input  logic [wcn_pkg::COORD_BITS-1:0]  i_car_x,
    input  logic [wcn_pkg::COORD_BITS-1:0]  i_car_y,
    input  logic [wcn_pkg::RADIUS_BITS-1:0] i_car_radius,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_hit,
    output logic signed [1:0]               o_normal_x,
    output logic signed [1:0]               o_normal_y
);
    import wcn_pkg::*;

    // command and status between controller and datapath
    t_cmd cmd;
    t_sts sts;

    // controller: accepts transfers while idle, steps the slot counter through
    // the area and holds the result valid until the downstream side takes it
    wcn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // datapath: wall memory with per-slot valid flops, one slot evaluated per
    // cycle on registered read data, hit and nearest-wall normal accumulated,
    // first wall kept on equal distance since only a strictly nearer one replaces it
    wcn_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_area         (i_area),
        .i_slot         (i_slot),
        .i_seg_vertical (i_seg_vertical),
        .i_seg_fixed    (i_seg_fixed),
        .i_seg_min      (i_seg_min),
        .i_seg_max      (i_seg_max),
        .i_seg_valid    (i_seg_valid),
        .i_car_x        (i_car_x),
        .i_car_y        (i_car_y),
        .i_car_radius   (i_car_radius),
        .o_hit          (o_hit),
        .o_normal_x     (o_normal_x),
        .o_normal_y     (o_normal_y)
    );

endmodule

// ----- tb/sv/tb_top.sv -----
// testbench for the axis-aligned wall collision and normal block
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wcn_pkg::*;

    localparam int CYCLE_LIMIT = 400_000;   // far beyond the slowest correct run
    localparam int TAIL_CYCLES = 40;        // room for a last query to complete, with slack
    localparam int IDLE_PCT    = 15;
    localparam int PRINT_CAP   = 200;
    localparam int AREA_TOP    = (1 << AREA_BITS) - 1;
    localparam int COORD_TOP   = (1 << COORD_BITS) - 1;

    // one input transfer, every field a port of its own
    typedef struct {
        logic                   func;
        logic [AREA_BITS-1:0]   area;
        logic [SLOT_BITS-1:0]   slot;
        logic                   seg_vertical;
        logic [COORD_BITS-1:0]  seg_fixed;
        logic [COORD_BITS-1:0]  seg_min;
        logic [COORD_BITS-1:0]  seg_max;
        logic                   seg_valid;
        logic [COORD_BITS-1:0]  car_x;
        logic [COORD_BITS-1:0]  car_y;
        logic [RADIUS_BITS-1:0] car_radius;
    } t_item;

    // the testbench's own copy of one wall slot
    typedef struct {
        bit vertical;
        bit valid;
        int fixed;
        int lo;
        int hi;
    } t_wall_entry;

    // expected outcome of one query
    typedef struct {
        int         seq;
        logic       hit;
        logic [1:0] nx;
        logic [1:0] ny;
    } t_contact;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   in_valid     = 1'b0;
    logic                   func         = FUNC_WRITE;
    logic [AREA_BITS-1:0]   area         = '0;
    logic [SLOT_BITS-1:0]   slot         = '0;
    logic                   seg_vertical = 1'b0;
    logic [COORD_BITS-1:0]  seg_fixed    = '0;
    logic [COORD_BITS-1:0]  seg_min      = '0;
    logic [COORD_BITS-1:0]  seg_max      = '0;
    logic                   seg_valid    = 1'b0;
    logic [COORD_BITS-1:0]  car_x        = '0;
    logic [COORD_BITS-1:0]  car_y        = '0;
    logic [RADIUS_BITS-1:0] car_radius   = '0;
    logic                   out_ready    = 1'b0;

    logic                   in_ready;
    logic                   out_valid;
    logic                   hit;
    logic signed [1:0]      normal_x;
    logic signed [1:0]      normal_y;

    t_wall_entry wall_map [AREAS*SLOTS_PER_AREA];
    t_contact    contact_q [$];
    int          err_count = 0;
    int          query_seq = 0;
    bit          calm      = 1'b0;   // when set neither side idles

    axis_wall_collision_and_normal dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_func         (func),
        .i_area         (area),
        .i_slot         (slot),
        .i_seg_vertical (seg_vertical),
        .i_seg_fixed    (seg_fixed),
        .i_seg_min      (seg_min),
        .i_seg_max      (seg_max),
        .i_seg_valid    (seg_valid),
        .i_car_x        (car_x),
        .i_car_y        (car_y),
        .i_car_radius   (car_radius),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_hit          (hit),
        .o_normal_x     (normal_x),
        .o_normal_y     (normal_y)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // load one slot of the local wall map, out-of-range writes are dropped
    function automatic void store_wall(input t_item it);
        int idx;
        if (it.area < AREAS && it.slot < SLOTS_PER_AREA) begin
            idx = int'(it.area) * SLOTS_PER_AREA + int'(it.slot);
            wall_map[idx].vertical = it.seg_vertical;
            wall_map[idx].valid    = it.seg_valid;
            wall_map[idx].fixed    = int'(it.seg_fixed);
            wall_map[idx].lo       = int'(it.seg_min);
            wall_map[idx].hi       = int'(it.seg_max);
        end
    endfunction

    // sweep the area: any touching wall sets hit, the nearest wall whose span
    // contains the car gives the normal, lower slot wins a tie
    function automatic t_contact predict_contact(input t_item it);
        t_contact    c;
        t_wall_entry w;
        int          perp;
        int          along;
        int          perp_dist;
        int          best;
        int          r;
        bit          found;
        c.seq = query_seq;
        c.hit = 1'b0;
        c.nx  = NORM_ZERO;
        c.ny  = NORM_ZERO;
        found = 1'b0;
        best  = 0;
        r     = int'(it.car_radius);
        if (it.area < AREAS) begin
            for (int s = 0; s < SLOTS_PER_AREA; s++) begin
                w = wall_map[int'(it.area) * SLOTS_PER_AREA + s];
                if (w.valid) begin
                    perp      = w.vertical ? int'(it.car_x) : int'(it.car_y);
                    along     = w.vertical ? int'(it.car_y) : int'(it.car_x);
                    perp_dist = (perp > w.fixed) ? perp - w.fixed : w.fixed - perp;
                    // an empty span can still overlap a wide enough car
                    if (perp_dist <= r && along + r >= w.lo && along - r <= w.hi)
                        c.hit = 1'b1;
                    if ((!found || perp_dist < best) && along >= w.lo && along <= w.hi) begin
                        found = 1'b1;
                        best  = perp_dist;
                        // a car lying on the wall points to the negative side
                        if (w.vertical) begin
                            c.nx = (perp > w.fixed) ? NORM_POS : NORM_NEG;
                            c.ny = NORM_ZERO;
                        end else begin
                            c.nx = NORM_ZERO;
                            c.ny = (perp > w.fixed) ? NORM_POS : NORM_NEG;
                        end
                    end
                end
            end
        end
        return c;
    endfunction

    // ------------------------------------------------------------------
    // item construction
    // ------------------------------------------------------------------

    // every field random, so unused fields are exercised as well
    function automatic t_item fill_random();
        t_item it;
        it.func         = 1'($urandom_range(1));
        it.area         = AREA_BITS'($urandom_range(AREA_TOP));
        it.slot         = SLOT_BITS'($urandom_range((1 << SLOT_BITS) - 1));
        it.seg_vertical = 1'($urandom_range(1));
        it.seg_fixed    = COORD_BITS'($urandom_range(COORD_TOP));
        it.seg_min      = COORD_BITS'($urandom_range(COORD_TOP));
        it.seg_max      = COORD_BITS'($urandom_range(COORD_TOP));
        it.seg_valid    = 1'($urandom_range(1));
        it.car_x        = COORD_BITS'($urandom_range(COORD_TOP));
        it.car_y        = COORD_BITS'($urandom_range(COORD_TOP));
        it.car_radius   = RADIUS_BITS'($urandom_range((1 << RADIUS_BITS) - 1));
        return it;
    endfunction

    function automatic t_item wall_item(input int a, input int s, input bit vert,
                                        input int fx, input int lo, input int hi,
                                        input bit ok);
        t_item it;
        it              = fill_random();
        it.func         = FUNC_WRITE;
        it.area         = AREA_BITS'(a);
        it.slot         = SLOT_BITS'(s);
        it.seg_vertical = vert;
        it.seg_fixed    = COORD_BITS'(fx);
        it.seg_min      = COORD_BITS'(lo);
        it.seg_max      = COORD_BITS'(hi);
        it.seg_valid    = ok;
        return it;
    endfunction

    function automatic t_item query_item(input int a, input int x, input int y, input int r);
        t_item it;
        it            = fill_random();
        it.func       = FUNC_QUERY;
        it.area       = AREA_BITS'(a);
        it.car_x      = COORD_BITS'(x);
        it.car_y      = COORD_BITS'(y);
        it.car_radius = RADIUS_BITS'(r);
        return it;
    endfunction

    // coordinates cluster in a narrow band so walls and cars often meet
    function automatic logic [COORD_BITS-1:0] pick_coord();
        int sel;
        sel = $urandom_range(99);
        if (sel < 45)
            return COORD_BITS'($urandom_range(COORD_TOP));
        if (sel < 90)
            return COORD_BITS'($urandom_range(448, 575));
        return $urandom_range(1) ? COORD_BITS'(COORD_TOP) : '0;
    endfunction

    function automatic t_item random_item();
        t_item                 it;
        int                    sel;
        logic [COORD_BITS-1:0] a;
        logic [COORD_BITS-1:0] b;
        it      = fill_random();
        it.func = ($urandom_range(99) < 40) ? FUNC_WRITE : FUNC_QUERY;
        sel     = $urandom_range(99);
        // most traffic in two dense areas, some spread, some out of range
        if (sel < 8)
            it.area = AREA_BITS'($urandom_range(AREAS, AREA_TOP));
        else if (sel < 55)
            it.area = AREA_BITS'($urandom_range(1));
        else
            it.area = AREA_BITS'($urandom_range(AREAS - 1));
        if (it.func == FUNC_WRITE) begin
            it.seg_valid = ($urandom_range(99) < 85);
            it.seg_fixed = pick_coord();
            a = pick_coord();
            b = pick_coord();
            if (a > b && $urandom_range(99) < 85) begin
                it.seg_min = b;
                it.seg_max = a;
            end else begin
                it.seg_min = a;
                it.seg_max = b;
            end
        end else begin
            it.car_x = pick_coord();
            it.car_y = pick_coord();
            sel = $urandom_range(99);
            if (sel < 15)
                it.car_radius = RADIUS_BITS'($urandom_range(15));
            else if (sel < 25)
                it.car_radius = RADIUS_BITS'((1 << RADIUS_BITS) - 1);
            else if (sel < 35)
                it.car_radius = '0;
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // present one item and hold it until the transfer, then record what it
    // means for the wall map or the results; valid stays high for a follow-on
    task automatic send_item(input t_item it);
        int gap;
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            // mostly short gaps, now and then a longer one that can outlast a whole sweep
            gap = ($urandom_range(3) != 0) ? $urandom_range(1, 4) : $urandom_range(5, 25);
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        func         <= it.func;
        area         <= it.area;
        slot         <= it.slot;
        seg_vertical <= it.seg_vertical;
        seg_fixed    <= it.seg_fixed;
        seg_min      <= it.seg_min;
        seg_max      <= it.seg_max;
        seg_valid    <= it.seg_valid;
        car_x        <= it.car_x;
        car_y        <= it.car_y;
        car_radius   <= it.car_radius;
        do @(posedge clk); while (!in_ready);
        if (it.func == FUNC_WRITE) begin
            store_wall(it);
        end else begin
            contact_q.push_back(predict_contact(it));
            query_seq++;
        end
    endtask

    task automatic release_input();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (contact_q.size() != 0)
            @(posedge clk);
    endtask

    // random traffic, writes to missing areas do not count
    task automatic run_random(input int n);
        t_item it;
        int    done;
        done = 0;
        while (done < n) begin
            it = random_item();
            send_item(it);
            if (!(it.func == FUNC_WRITE && it.area >= AREAS))
                done++;
        end
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    task automatic report_error(input string msg);
        if (err_count < PRINT_CAP)
            $display("ERROR %0t: %s", $time, msg);
        err_count++;
    endtask

    always @(posedge clk) begin
        out_ready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end

    // each result transfer is held against the oldest expected contact
    always @(posedge clk) begin : check_result
        t_contact want;
        if (rst_n && out_valid && out_ready) begin
            if (contact_q.size() == 0) begin
                report_error("result transfer with no query outstanding");
            end else begin
                want = contact_q.pop_front();
                if (hit !== want.hit)
                    report_error($sformatf("query %0d: hit %b, expected %b",
                                           want.seq, hit, want.hit));
                if (normal_x !== want.nx)
                    report_error($sformatf("query %0d: normal_x %b, expected %b",
                                           want.seq, normal_x, want.nx));
                if (normal_y !== want.ny)
                    report_error($sformatf("query %0d: normal_y %b, expected %b",
                                           want.seq, normal_y, want.ny));
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // nothing loaded yet: every query is a miss with a zero normal
    task automatic test_empty_store();
        send_item(query_item(0, 512, 512, 255));
        send_item(query_item(AREAS - 1, 0, 0, 0));
        send_item(query_item(AREA_TOP, COORD_TOP, COORD_TOP, 255));
    endtask

    // nearest containing wall picks the normal, lower slot on a tie
    task automatic test_nearest_wall();
        send_item(wall_item(0, 0, 1'b0, 500, 100, 900, 1'b1));
        send_item(wall_item(0, 1, 1'b1, 200, 0, COORD_TOP, 1'b1));
        send_item(query_item(0, 300, 510, 10));               // just above the horizontal
        send_item(query_item(0, 300, 500, 0));                // on it, zero radius
        send_item(query_item(0, COORD_TOP, COORD_TOP, 255));  // only the vertical contains it
        send_item(wall_item(2, 0, 1'b1, 100, 0, COORD_TOP, 1'b1));
        send_item(wall_item(2, 1, 1'b0, 300, 0, COORD_TOP, 1'b1));
        send_item(query_item(2, 200, 200, 0));                // equal distances
    endtask

    task automatic test_special_cases();
        // write to an area that does not exist, then query it
        send_item(wall_item(AREAS, 0, 1'b0, 500, 0, COORD_TOP, 1'b1));
        send_item(query_item(AREAS, 500, 500, 255));
        send_item(query_item(AREA_TOP, 500, 500, 255));
        // empty span in the last slot of the last area
        send_item(wall_item(AREAS - 1, SLOTS_PER_AREA - 1, 1'b0, 500, 600, 400, 1'b1));
        send_item(query_item(AREAS - 1, 500, 500, 255));
        send_item(query_item(AREAS - 1, 500, 300, 0));
        // same slot written back as invalid
        send_item(wall_item(AREAS - 1, SLOTS_PER_AREA - 1, 1'b0, 500, 0, COORD_TOP, 1'b0));
        send_item(query_item(AREAS - 1, 500, 500, 255));
        // walls on the coordinate extremes, cars sitting right on them
        send_item(wall_item(3, 0, 1'b0, 0, 0, COORD_TOP, 1'b1));
        send_item(wall_item(3, SLOTS_PER_AREA - 1, 1'b1, COORD_TOP, 0, COORD_TOP, 1'b1));
        send_item(query_item(3, 0, 0, 0));
        send_item(query_item(3, COORD_TOP, COORD_TOP, 255));
    endtask

    task automatic test_random_traffic();
        run_random(500);
    endtask

    // long stretch where neither side idles
    task automatic test_burst_no_idle();
        calm = 1'b1;
        run_random(250);
        calm = 1'b0;
    endtask

    // sender holds off until every result is back, then carries on
    task automatic test_drain_pause();
        run_random(40);
        release_input();
        wait_drained();
        run_random(240);
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        foreach (wall_map[i])
            wall_map[i] = '{default: 0};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_store();
        test_nearest_wall();
        test_special_cases();
        test_random_traffic();
        test_burst_no_idle();
        test_drain_pause();

        release_input();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (contact_q.size() != 0)
            report_error($sformatf("%0d results never arrived", contact_q.size()));
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog on a cycle count
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

endmodule
